FILE: hdl/dtah_pkg.sv
`timescale 1ns / 1ps
package dtah_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OBS_SCAN,
        ST_OBS_WRITE,
        ST_TICK_SCAN,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DONE
    } state_t;

    localparam logic [1:0] MODE_OBSERVE = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    localparam logic [7:0] CFG_TYPE_A  = 8'd0;
    localparam logic [7:0] CFG_TYPE_B  = 8'd1;
    localparam logic [7:0] CFG_TIMEOUT = 8'd2;
    localparam logic [7:0] CFG_RECENT  = 8'd3;

    localparam logic [7:0] GAP_MARKER = 8'h81;

    localparam logic [31:0] RST_TYPE_A  = 32'd1;
    localparam logic [31:0] RST_TYPE_B  = 32'd2;
    localparam logic [31:0] RST_TIMEOUT = 32'd10000;
    localparam logic [31:0] RST_RECENT  = 32'd2000;

    typedef struct packed {
        logic [47:0] address;
        logic [7:0]  dtype;
        logic [15:0] id;
        logic [7:0]  culture;
        logic [7:0]  rssi;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  slot_out;
        logic        entry_active;
        logic [47:0] address_out;
        logic [7:0]  type_out;
        logic [15:0] id_out;
        logic [7:0]  culture_out;
        logic [7:0]  current_strength_out;
        logic [7:0]  history_sample;
        logic [6:0]  history_fill;
        logic [5:0]  history_write_pos;
    } result_t;

endpackage

FILE: hdl/dtah_ram.sv
`timescale 1ns / 1ps
module dtah_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hdl/dtah_entry_file.sv
`timescale 1ns / 1ps
module dtah_entry_file #(
    parameter int N  = 16,
    parameter int IW = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IW-1:0]    rd_idx,
    output dtah_pkg::entry_t rd_data,
    input  logic             wr_en,
    input  logic [IW-1:0]    wr_idx,
    input  dtah_pkg::entry_t wr_data
);
    import dtah_pkg::*;

    entry_t ent_reg [N];

    assign rd_data = ent_reg[rd_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                ent_reg[i] <= '0;
            end
        end else if (wr_en) begin
            ent_reg[wr_idx] <= wr_data;
        end
    end
endmodule

FILE: hdl/device_table_with_aging_and_rssi_history.sv
`timescale 1ns / 1ps
// Device table keyed by 48-bit address with timeout aging and a per-entry RSSI ring.
// One item is taken at a time; s_ready is high only while the sequencer is idle.
// An observation walks every slot through one shared compare unit (address match,
// free-slot and oldest-timestamp search), then writes the chosen slot. A tick walks
// every slot through the shared age subtract/compare unit and writes at most one ring
// sample per cycle into the single ring RAM. A read passes through an address state
// and a data state, since the ring RAM read is registered. A rejected observation or
// an unused mode goes straight to ST_DONE. The result sits in an output register,
// so the next item is taken while a result waits; the sequencer only stalls when it
// needs the output register again. Ring positions are never cleared: a claim resets
// the fill count to zero, and a position at or above the fill count reads as 0.
module device_table_with_aging_and_rssi_history #(
    parameter int MAX_ENTRIES   = 16,
    parameter int HISTORY_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [31:0]        s_now_ms,
    input  logic [47:0]        s_address,
    input  logic [7:0]         s_device_type,
    input  logic [15:0]        s_device_id,
    input  logic [7:0]         s_culture_code,
    input  logic signed [7:0]  s_signal_strength,
    input  logic [3:0]         s_slot_index,
    input  logic [5:0]         s_history_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_accepted,
    output logic [3:0]         m_slot_out,
    output logic               m_entry_active,
    output logic [47:0]        m_address_out,
    output logic [7:0]         m_type_out,
    output logic [15:0]        m_id_out,
    output logic [7:0]         m_culture_out,
    output logic signed [7:0]  m_current_strength_out,
    output logic signed [7:0]  m_history_sample,
    output logic [6:0]         m_history_fill,
    output logic [5:0]         m_history_write_pos,
    output logic [4:0]         m_active_total,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import dtah_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int RAW = IW + HW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
    localparam logic [HW-1:0] LAST_POS = HW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FULL     = FW'(HISTORY_DEPTH);
    localparam logic [8:0]    HD9      = 9'(HISTORY_DEPTH);
    localparam logic [7:0]    N8       = 8'(MAX_ENTRIES);

    // configuration
    logic [7:0]  type_a_reg, type_b_reg;
    logic [31:0] timeout_reg, recent_reg;

    // sequencer and latched beat
    state_t          state_reg, state_next;
    logic [IW-1:0]   idx_reg;
    logic [31:0]     now_reg;
    logic [47:0]     addr_reg;
    logic [7:0]      dtype_reg;
    logic [15:0]     id_reg;
    logic [7:0]      culture_reg;
    logic [7:0]      rssi_reg;
    logic [3:0]      rs_reg;
    logic [5:0]      rh_reg;

    // per-slot control state
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [HW-1:0]          wpos_reg [MAX_ENTRIES];
    logic [FW-1:0]          fill_reg [MAX_ENTRIES];
    logic [CW-1:0]          count_reg;

    // observation search
    logic          match_reg, free_reg, vok_reg;
    logic [IW-1:0] victim_reg;
    logic [31:0]   oldest_reg;

    result_t res_reg, m_res_reg;
    logic    m_valid_reg;
    logic [4:0] m_total_reg;

    logic accept_in, out_free, last_step;
    logic [IW-1:0] rd_idx, rs_idx;
    logic [HW-1:0] rh_idx;
    logic [7:0]    rs_ext;
    logic [8:0]    rh_ext;
    entry_t        ent, wr_ent;
    logic          ent_we;
    logic [31:0]   age;
    logic          too_old, is_recent, hit, older;
    logic          ram_we, ram_re;
    logic [RAW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          s_ok, h_ok;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept_in = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (idx_reg == LAST_IDX);

    assign rs_ext = {4'b0, rs_reg};
    assign rh_ext = {3'b0, rh_reg};
    assign rs_idx = rs_ext[IW-1:0];
    assign rh_idx = rh_ext[HW-1:0];
    assign rd_idx = (state_reg == ST_RD_DATA) ? rs_idx : idx_reg;

    // shared compare unit: address match, oldest search, age tests
    assign age       = now_reg - ent.seen;
    assign too_old   = age > timeout_reg;
    assign is_recent = age < recent_reg;
    assign hit       = valid_reg[idx_reg] && (ent.address == addr_reg);
    assign older     = ent.seen < oldest_reg;

    assign s_ok = rs_ext < N8;
    assign h_ok = (rh_ext < HD9) &&
                  ((fill_reg[rs_idx] == FULL) || (rh_ext < 9'(fill_reg[rs_idx])));

    dtah_entry_file #(.N(MAX_ENTRIES), .IW(IW)) u_entries (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (rd_idx),
        .rd_data (ent),
        .wr_en   (ent_we),
        .wr_idx  (victim_reg),
        .wr_data (wr_ent)
    );

    dtah_ram #(.WIDTH(8), .DEPTH(2 ** RAW)) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_we         = (state_reg == ST_OBS_WRITE) && vok_reg;
    assign wr_ent.address = addr_reg;
    assign wr_ent.dtype   = dtype_reg;
    assign wr_ent.id      = id_reg;
    assign wr_ent.culture = culture_reg;
    assign wr_ent.rssi    = rssi_reg;
    assign wr_ent.seen    = now_reg;

    // push one sample per live slot during a tick
    assign ram_we    = (state_reg == ST_TICK_SCAN) && valid_reg[idx_reg] && !too_old;
    assign ram_waddr = {idx_reg, wpos_reg[idx_reg]};
    assign ram_wdata = is_recent ? ent.rssi : GAP_MARKER;
    assign ram_re    = (state_reg == ST_RD_ADDR);
    assign ram_raddr = {rs_idx, rh_idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    priority case (s_mode)
                        MODE_OBSERVE: begin
                            state_next = (s_device_type == type_a_reg ||
                                          s_device_type == type_b_reg) ?
                                         ST_OBS_SCAN : ST_DONE;
                        end
                        MODE_TICK: state_next = ST_TICK_SCAN;
                        MODE_READ: state_next = ST_RD_ADDR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_OBS_SCAN:  state_next = last_step ? ST_OBS_WRITE : ST_OBS_SCAN;
            ST_OBS_WRITE: state_next = ST_DONE;
            ST_TICK_SCAN: state_next = last_step ? ST_DONE : ST_TICK_SCAN;
            ST_RD_ADDR:   state_next = ST_RD_DATA;
            ST_RD_DATA:   state_next = ST_DONE;
            ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_a_reg  <= RST_TYPE_A[7:0];
            type_b_reg  <= RST_TYPE_B[7:0];
            timeout_reg <= RST_TIMEOUT;
            recent_reg  <= RST_RECENT;
        end else if (cfg_valid && cfg_ready) begin
            priority case (cfg_index)
                CFG_TYPE_A:  type_a_reg  <= cfg_data[7:0];
                CFG_TYPE_B:  type_b_reg  <= cfg_data[7:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_RECENT:  recent_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // latch the input beat
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            now_reg     <= s_now_ms;
            addr_reg    <= s_address;
            dtype_reg   <= s_device_type;
            id_reg      <= s_device_id;
            culture_reg <= s_culture_code;
            rssi_reg    <= s_signal_strength;
            rs_reg      <= s_slot_index;
            rh_reg      <= s_history_index;
        end
    end

    // slot walk and search bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            match_reg  <= 1'b0;
            free_reg   <= 1'b0;
            vok_reg    <= 1'b0;
            victim_reg <= '0;
            oldest_reg <= '1;
        end else if (accept_in) begin
            idx_reg    <= '0;
            match_reg  <= 1'b0;
            free_reg   <= 1'b0;
            vok_reg    <= 1'b0;
            victim_reg <= '0;
            oldest_reg <= '1;
        end else if (state_reg == ST_OBS_SCAN || state_reg == ST_TICK_SCAN) begin
            idx_reg <= idx_reg + 1'b1;
            if (state_reg == ST_OBS_SCAN && !match_reg) begin
                if (hit) begin
                    match_reg  <= 1'b1;
                    vok_reg    <= 1'b1;
                    victim_reg <= idx_reg;
                end else if (!valid_reg[idx_reg]) begin
                    free_reg   <= 1'b1;
                    vok_reg    <= 1'b1;
                    victim_reg <= idx_reg;
                end else if (!free_reg && older) begin
                    oldest_reg <= ent.seen;
                    vok_reg    <= 1'b1;
                    victim_reg <= idx_reg;
                end
            end
        end
    end

    // valid flags, ring pointers, active count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                wpos_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else if (state_reg == ST_OBS_WRITE) begin
            if (vok_reg && !match_reg) begin
                valid_reg[victim_reg] <= 1'b1;
                wpos_reg[victim_reg]  <= '0;
                fill_reg[victim_reg]  <= '0;
                if (free_reg) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end else if (state_reg == ST_TICK_SCAN && valid_reg[idx_reg]) begin
            if (too_old) begin
                valid_reg[idx_reg] <= 1'b0;
                count_reg          <= count_reg - 1'b1;
            end else begin
                wpos_reg[idx_reg] <= (wpos_reg[idx_reg] == LAST_POS) ? '0 :
                                     wpos_reg[idx_reg] + 1'b1;
                if (fill_reg[idx_reg] != FULL) begin
                    fill_reg[idx_reg] <= fill_reg[idx_reg] + 1'b1;
                end
            end
        end
    end

    // build the result
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            res_reg <= '0;
        end else if (state_reg == ST_OBS_WRITE && vok_reg) begin
            res_reg.accepted <= 1'b1;
            res_reg.slot_out <= 4'((IW + 4)'(victim_reg));
        end else if (state_reg == ST_RD_DATA) begin
            res_reg.slot_out <= rs_reg;
            if (s_ok) begin
                res_reg.entry_active         <= valid_reg[rs_idx];
                res_reg.address_out          <= ent.address;
                res_reg.type_out             <= ent.dtype;
                res_reg.id_out               <= ent.id;
                res_reg.culture_out          <= ent.culture;
                res_reg.current_strength_out <= ent.rssi;
                res_reg.history_sample       <= h_ok ? ram_rdata : 8'd0;
                res_reg.history_fill         <= 7'((FW + 7)'(fill_reg[rs_idx]));
                res_reg.history_write_pos    <= 6'((HW + 6)'(wpos_reg[rs_idx]));
            end
        end
    end

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_res_reg   <= res_reg;
            m_total_reg <= 5'((CW + 5)'(count_reg));
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_accepted             = m_res_reg.accepted;
    assign m_slot_out             = m_res_reg.slot_out;
    assign m_entry_active         = m_res_reg.entry_active;
    assign m_address_out          = m_res_reg.address_out;
    assign m_type_out             = m_res_reg.type_out;
    assign m_id_out               = m_res_reg.id_out;
    assign m_culture_out          = m_res_reg.culture_out;
    assign m_current_strength_out = m_res_reg.current_strength_out;
    assign m_history_sample       = m_res_reg.history_sample;
    assign m_history_fill         = m_res_reg.history_fill;
    assign m_history_write_pos    = m_res_reg.history_write_pos;
    assign m_active_total         = m_total_reg;
endmodule
